// ===== design/otrs_pkg.sv =====
// Package for the OLED text refresh sequencer: beat types, phase and state
// enums, protocol constants, font, text and start-up command tables.
// No dependencies.
`timescale 1ns / 1ps

package otrs_pkg;

  // Default sizes
  localparam int unsigned LabelBytesDef   = 96;
  localparam int unsigned TimeBytesDef    = 72;
  localparam int unsigned DisplayWidthDef = 128;
  localparam int unsigned PageCountDef    = 8;
  localparam int unsigned MaxChunkDef     = 7;

  // Protocol constants
  localparam logic [7:0]  CTRL_CMD   = 8'h00;
  localparam logic [7:0]  CTRL_DATA  = 8'h40;
  localparam logic [7:0]  CMD_COLS   = 8'h21;
  localparam logic [7:0]  CMD_PAGES  = 8'h22;
  localparam logic [4:0]  INIT_LEN   = 5'd25;
  localparam logic [19:0] TIME_CLAMP = 20'd999999;
  localparam logic [4:0]  GLYPH_BLANK = 5'd31;
  localparam logic [15:0] REFRESH_RST = 16'd100;

  // Configuration register indexes
  localparam logic [1:0] CFG_REFRESH    = 2'd0;
  localparam logic [1:0] CFG_LABEL_PAGE = 2'd1;
  localparam logic [1:0] CFG_TIME_PAGE  = 2'd2;

  typedef struct packed {
    logic        bus_busy;
    logic        bus_error;
    logic [1:0]  mission_mode;
    logic [31:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic        packet_valid;
    logic [3:0]  byte_count;
    logic [63:0] packet_bytes;
    logic        reset_bus;
    logic        failed;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_INIT, PH_CLEAR_WIN, PH_CLEAR_DATA, PH_RUN, PH_DRAW_WIN, PH_DRAW_DATA, PH_FAILED
  } phase_e;

  typedef enum logic [3:0] {
    S_BOOT_L, S_BOOT_LW, S_BOOT_T, S_BOOT_TW, S_IDLE, S_SVC, S_CHK, S_RL, S_RLW,
    S_RT, S_RTW, S_PLAN, S_GRD, S_GWR, S_FIN, S_OUT
  } seq_state_e;

  typedef enum logic [1:0] {R_IDLE, R_DIGIT, R_WRITE} ren_state_e;

  typedef enum logic [2:0] {SRC_INIT, SRC_WIN, SRC_ZERO, SRC_LABEL, SRC_TIME} src_e;

  // Render request from the sequencer
  typedef struct packed {
    logic        start;
    logic        is_time;
    logic [1:0]  mode;
    logic [31:0] ms;
  } ren_req_t;

  // Buffer write from the renderer
  typedef struct packed {
    logic       we_label;
    logic       we_time;
    logic [6:0] addr;
    logic [7:0] data;
  } ren_wr_t;

  function automatic logic [7:0] init_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0: b = 8'hAE;  5'd1: b = 8'hD5;  5'd2: b = 8'h80;  5'd3: b = 8'hA8;
      5'd4: b = 8'h3F;  5'd5: b = 8'hD3;  5'd6: b = 8'h00;  5'd7: b = 8'h40;
      5'd8: b = 8'h8D;  5'd9: b = 8'h14;  5'd10: b = 8'h20; 5'd11: b = 8'h00;
      5'd12: b = 8'hA1; 5'd13: b = 8'hC8; 5'd14: b = 8'hDA; 5'd15: b = 8'h12;
      5'd16: b = 8'h81; 5'd17: b = 8'h7F; 5'd18: b = 8'hD9; 5'd19: b = 8'hF1;
      5'd20: b = 8'hDB; 5'd21: b = 8'h40; 5'd22: b = 8'hA4; 5'd23: b = 8'hA6;
      5'd24: b = 8'hAF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Glyph column; glyph codes follow "0123456789ABCDEIMPSTOCL:.", blank otherwise
  function automatic logic [7:0] font_col(input logic [4:0] g, input logic [2:0] sub);
    logic [39:0] c;
    case (g)
      5'd0:  c = 40'h3E_51_49_45_3E; 5'd1:  c = 40'h00_42_7F_40_00;
      5'd2:  c = 40'h42_61_51_49_46; 5'd3:  c = 40'h21_41_45_4B_31;
      5'd4:  c = 40'h18_14_12_7F_10; 5'd5:  c = 40'h27_45_45_45_39;
      5'd6:  c = 40'h3C_4A_49_49_30; 5'd7:  c = 40'h01_71_09_05_03;
      5'd8:  c = 40'h36_49_49_49_36; 5'd9:  c = 40'h06_49_49_29_1E;
      5'd10: c = 40'h7E_11_11_11_7E; 5'd11: c = 40'h7F_49_49_49_36;
      5'd12: c = 40'h3E_41_41_41_22; 5'd13: c = 40'h7F_41_41_22_1C;
      5'd14: c = 40'h7F_49_49_49_41; 5'd15: c = 40'h00_41_7F_41_00;
      5'd16: c = 40'h7F_02_0C_02_7F; 5'd17: c = 40'h7F_09_09_09_06;
      5'd18: c = 40'h46_49_49_49_31; 5'd19: c = 40'h01_01_7F_01_01;
      5'd20: c = 40'h3E_41_41_41_3E; 5'd21: c = 40'h3E_41_41_41_22;
      5'd22: c = 40'h7F_40_40_40_40; 5'd23: c = 40'h00_36_36_00_00;
      5'd24: c = 40'h00_60_60_00_00;
      default: c = 40'h0;
    endcase
    case (sub)
      3'd0: return c[39:32];
      3'd1: return c[31:24];
      3'd2: return c[23:16];
      3'd3: return c[15:8];
      3'd4: return c[7:0];
      default: return 8'h00;
    endcase
  endfunction

  // Glyph code of character k of a mode label, up to 16 characters
  function automatic logic [4:0] mode_glyph(input logic [1:0] mode, input logic [4:0] k);
    logic [79:0] t;
    case (mode)
      2'd0: t = {5'd18, 5'd14, 5'd22, 5'd14, 5'd12, 5'd19, 5'd31, 5'd16,
                 5'd20, 5'd13, 5'd14, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31};
      2'd1: t = {5'd17, 5'd10, 5'd1,  5'd8,  5'd31, 5'd18, 5'd19, 5'd20,
                 5'd17, 5'd31, 5'd19, 5'd15, 5'd16, 5'd14, 5'd31, 5'd31};
      2'd2: t = {5'd17, 5'd11, 5'd2,  5'd2,  5'd31, 5'd11, 5'd31, 5'd19,
                 5'd15, 5'd16, 5'd14, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31};
      default: t = {5'd17, 5'd11, 5'd2,  5'd3,  5'd31, 5'd13, 5'd31, 5'd19,
                    5'd15, 5'd16, 5'd14, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31};
    endcase
    if (k[4]) return GLYPH_BLANK;
    return t[5*(15-int'(k[3:0])) +: 5];
  endfunction

  function automatic logic [19:0] pow10(input logic [2:0] i);
    case (i)
      3'd0: return 20'd100000;
      3'd1: return 20'd10000;
      3'd2: return 20'd1000;
      3'd3: return 20'd100;
      3'd4: return 20'd10;
      default: return 20'd1;
    endcase
  endfunction

  // Column/page window command bytes
  function automatic logic [7:0] win_byte(input logic [2:0] i, input logic [7:0] last,
                                          input logic [2:0] page);
    case (i)
      3'd0: return CMD_COLS;
      3'd1: return 8'h00;
      3'd2: return last;
      3'd3: return CMD_PAGES;
      default: return {5'd0, page};
    endcase
  endfunction

endpackage

// ===== design/otrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module otrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/otrs_render.sv =====
// Text renderer: splits the time into decimal digits with one shared
// compare/subtract unit, then writes glyph columns one byte per cycle.
// Depends on otrs_pkg.
`timescale 1ns / 1ps

module otrs_render #(
  parameter int unsigned LABEL_BYTES = otrs_pkg::LabelBytesDef,
  parameter int unsigned TIME_BYTES  = otrs_pkg::TimeBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  otrs_pkg::ren_req_t req_i,
  output otrs_pkg::ren_wr_t  wr_o,
  output logic              done_o
);

  localparam int unsigned LblChars = LABEL_BYTES / 6;
  localparam int unsigned TimChars = TIME_BYTES / 6;

  otrs_pkg::ren_state_e state_q, state_d;
  logic        is_time_q, is_time_d;
  logic [1:0]  mode_q, mode_d;
  logic [19:0] val_q, val_d;
  logic [2:0]  pidx_q, pidx_d;
  logic [3:0]  dig_q [6];
  logic [3:0]  dig_d [6];
  logic [7:0]  col_q, col_d;
  logic [4:0]  char_q, char_d;
  logic [2:0]  sub_q, sub_d;

  logic [7:0]  len_last;
  logic [4:0]  chars;
  logic [4:0]  glyph;
  logic [7:0]  col_byte;
  logic        ge;
  logic        last_col;

  assign len_last = is_time_q ? 8'(TIME_BYTES - 1) : 8'(LABEL_BYTES - 1);
  assign chars    = is_time_q ? 5'(TimChars) : 5'(LblChars);
  assign ge       = val_q >= otrs_pkg::pow10(pidx_q);
  assign last_col = col_q == len_last;

  // Glyph of the current character
  always_comb begin
    if (is_time_q) begin
      case (char_q)
        5'd0: glyph = 5'd19;
        5'd2: glyph = {1'b0, dig_q[0]};
        5'd3: glyph = {1'b0, dig_q[1]};
        5'd4: glyph = {1'b0, dig_q[2]};
        5'd5: glyph = 5'd24;
        5'd6: glyph = {1'b0, dig_q[3]};
        5'd7: glyph = {1'b0, dig_q[4]};
        5'd8: glyph = {1'b0, dig_q[5]};
        5'd9: glyph = 5'd18;
        default: glyph = otrs_pkg::GLYPH_BLANK;
      endcase
    end else begin
      glyph = otrs_pkg::mode_glyph(mode_q, char_q);
    end
  end

  assign col_byte = (char_q < chars && sub_q != 3'd5) ? otrs_pkg::font_col(glyph, sub_q)
                                                     : 8'h00;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otrs_pkg::R_IDLE: begin
        if (req_i.start) begin
          state_d = req_i.is_time ? otrs_pkg::R_DIGIT : otrs_pkg::R_WRITE;
        end
      end
      otrs_pkg::R_DIGIT: begin
        if (!ge && pidx_q == 3'd5) begin
          state_d = otrs_pkg::R_WRITE;
        end
      end
      otrs_pkg::R_WRITE: begin
        if (last_col) begin
          state_d = otrs_pkg::R_IDLE;
        end
      end
      default: state_d = otrs_pkg::R_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    is_time_d = is_time_q;
    mode_d    = mode_q;
    val_d     = val_q;
    pidx_d    = pidx_q;
    dig_d     = dig_q;
    col_d     = col_q;
    char_d    = char_q;
    sub_d     = sub_q;
    wr_o      = '0;
    done_o    = 1'b0;
    unique case (state_q)
      otrs_pkg::R_IDLE: begin
        if (req_i.start) begin
          is_time_d = req_i.is_time;
          mode_d    = req_i.mode;
          val_d     = (req_i.ms > 32'(otrs_pkg::TIME_CLAMP)) ? otrs_pkg::TIME_CLAMP
                                                            : req_i.ms[19:0];
          pidx_d    = 3'd0;
          for (int i = 0; i < 6; i++) dig_d[i] = 4'd0;
          col_d     = 8'd0;
          char_d    = 5'd0;
          sub_d     = 3'd0;
        end
      end
      otrs_pkg::R_DIGIT: begin
        if (ge) begin
          val_d        = val_q - otrs_pkg::pow10(pidx_q);
          dig_d[pidx_q] = dig_q[pidx_q] + 4'd1;
        end else if (pidx_q != 3'd5) begin
          pidx_d = pidx_q + 3'd1;
        end
      end
      otrs_pkg::R_WRITE: begin
        wr_o.we_label = !is_time_q;
        wr_o.we_time  = is_time_q;
        wr_o.addr     = col_q[6:0];
        wr_o.data     = col_byte;
        done_o        = last_col;
        col_d         = col_q + 8'd1;
        if (sub_q == 3'd5) begin
          sub_d  = 3'd0;
          char_d = char_q + 5'd1;
        end else begin
          sub_d = sub_q + 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otrs_pkg::R_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_time_q <= is_time_d;
    mode_q    <= mode_d;
    val_q     <= val_d;
    pidx_q    <= pidx_d;
    dig_q     <= dig_d;
    col_q     <= col_d;
    char_q    <= char_d;
    sub_q     <= sub_d;
  end

endmodule

// ===== design/oled_text_refresh_sequencer.sv =====
// Top level of the OLED text refresh sequencer: tick sequencer, packet
// builder, configuration registers and the two column buffers.
// Depends on otrs_pkg, otrs_ram and otrs_render.
//
// Usage: one input beat per 1 ms tick carries the bus flags, the mission
// mode and the elapsed time; each tick returns exactly one output beat,
// which holds an I2C write packet (control byte plus up to MAX_CHUNK bytes,
// always six for a column/page window) or no packet.
// Configuration writes on the cfg channel are always taken.
// Per tick the sequencer does its bookkeeping, then reads each packet byte
// through the buffer read port one at a time. Before that it re-renders
// the label or the time when, at a refresh divider wrap, the mode or time
// has changed; the time is split into digits before its columns are written.
// One tick at a time:
// in_ready_o is low from acceptance until the output beat is taken.
// After reset the buffers are filled with the start-up text, label first
// and then time, before the first beat is accepted.
// When the receiver stalls, the output beat holds and no new tick is taken.
`timescale 1ns / 1ps

module oled_text_refresh_sequencer #(
  parameter int unsigned LABEL_BYTES   = otrs_pkg::LabelBytesDef,
  parameter int unsigned TIME_BYTES    = otrs_pkg::TimeBytesDef,
  parameter int unsigned DISPLAY_WIDTH = otrs_pkg::DisplayWidthDef,
  parameter int unsigned PAGE_COUNT    = otrs_pkg::PageCountDef,
  parameter int unsigned MAX_CHUNK     = otrs_pkg::MaxChunkDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  otrs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output otrs_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned LblAw = $clog2(LABEL_BYTES);
  localparam int unsigned TimAw = $clog2(TIME_BYTES);
  // Largest packet: a window is six bytes, data chunks up to MAX_CHUNK
  localparam int unsigned MaxBytes = (MAX_CHUNK > 6) ? MAX_CHUNK + 1 : 7;

  // Configuration registers
  logic [15:0] refresh_q;
  logic [2:0]  label_page_q, time_page_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q    <= otrs_pkg::REFRESH_RST;
      label_page_q <= 3'd0;
      time_page_q  <= 3'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        otrs_pkg::CFG_REFRESH:    refresh_q    <= cfg_data_i;
        otrs_pkg::CFG_LABEL_PAGE: label_page_q <= cfg_data_i[2:0];
        otrs_pkg::CFG_TIME_PAGE:  time_page_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  otrs_pkg::seq_state_e state_q, state_d;
  otrs_pkg::phase_e     phase_q, phase_d;
  otrs_pkg::src_e       src_q, src_d;
  otrs_pkg::in_item_t   in_q, in_d;
  logic        pend_q, pend_d;
  logic [4:0]  init_pos_q, init_pos_d;
  logic [3:0]  clr_page_q, clr_page_d;
  logic [7:0]  clr_col_q, clr_col_d;
  logic [15:0] div_q, div_d;
  logic [1:0]  shown_mode_q, shown_mode_d;
  logic [31:0] shown_time_q, shown_time_d;
  logic        lbl_stale_q, lbl_stale_d, tim_stale_q, tim_stale_d;
  logic        draw_src_q, draw_src_d;
  logic [7:0]  draw_span_q, draw_span_d, draw_pos_q, draw_pos_d;
  logic [2:0]  draw_page_q, draw_page_d;
  logic        nl_q, nl_d, nt_q, nt_d;
  logic [2:0]  n_q, n_d, i_q, i_d;
  logic [7:0]  base_q, base_d, wl_q, wl_d;
  logic [2:0]  wp_q, wp_d;
  logic        pv_q, pv_d, rb_q, rb_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] pkt_q, pkt_d;

  // Service of the pending transfer
  logic        svc_pend, svc_fail, svc_go;
  logic [15:0] div_inc;
  assign svc_pend = pend_q && in_q.bus_busy;
  assign svc_fail = (phase_q == otrs_pkg::PH_FAILED) ||
                    (pend_q && !in_q.bus_busy && in_q.bus_error);
  assign svc_go   = !svc_pend && !svc_fail;
  assign div_inc  = div_q + 16'd1;

  // Chunk sizing; window packets always carry six bytes
  logic [7:0] rem;
  logic [2:0] chunk;
  always_comb begin
    unique case (phase_q)
      otrs_pkg::PH_INIT:       rem = {3'd0, otrs_pkg::INIT_LEN - init_pos_q};
      otrs_pkg::PH_CLEAR_DATA: rem = 8'(DISPLAY_WIDTH) - clr_col_q;
      otrs_pkg::PH_DRAW_DATA:  rem = (draw_pos_q < draw_span_q) ? draw_span_q - draw_pos_q
                                                               : 8'd0;
      default:                 rem = 8'd6;
    endcase
    if (phase_q == otrs_pkg::PH_CLEAR_WIN || phase_q == otrs_pkg::PH_DRAW_WIN) begin
      chunk = 3'd6;
    end else begin
      chunk = (rem > 8'(MAX_CHUNK)) ? 3'(MAX_CHUNK) : rem[2:0];
    end
  end

  // Renderer and buffers
  otrs_pkg::ren_req_t ren_req;
  otrs_pkg::ren_wr_t  ren_wr;
  logic               ren_done;
  logic [7:0]         rd_addr;
  logic [7:0]         lbl_rdata, tim_rdata;

  otrs_render #(
    .LABEL_BYTES(LABEL_BYTES),
    .TIME_BYTES (TIME_BYTES)
  ) u_render (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ren_req),
    .wr_o  (ren_wr),
    .done_o(ren_done)
  );

  assign rd_addr = base_q + {5'd0, i_q};

  otrs_ram #(.WIDTH(8), .DEPTH(LABEL_BYTES)) u_label_ram (
    .clk_i  (clk_i),
    .we_i   (ren_wr.we_label),
    .waddr_i(LblAw'(ren_wr.addr)),
    .wdata_i(ren_wr.data),
    .raddr_i(LblAw'(rd_addr)),
    .rdata_o(lbl_rdata)
  );

  otrs_ram #(.WIDTH(8), .DEPTH(TIME_BYTES)) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (ren_wr.we_time),
    .waddr_i(TimAw'(ren_wr.addr)),
    .wdata_i(ren_wr.data),
    .raddr_i(TimAw'(rd_addr)),
    .rdata_o(tim_rdata)
  );

  // Current packet byte
  logic [7:0] pkt_byte;
  always_comb begin
    case (src_q)
      otrs_pkg::SRC_INIT:  pkt_byte = otrs_pkg::init_byte(5'(rd_addr));
      otrs_pkg::SRC_WIN:   pkt_byte = otrs_pkg::win_byte(i_q, wl_q, wp_q);
      otrs_pkg::SRC_LABEL: pkt_byte = lbl_rdata;
      otrs_pkg::SRC_TIME:  pkt_byte = tim_rdata;
      default:             pkt_byte = 8'h00;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otrs_pkg::S_BOOT_L:  state_d = otrs_pkg::S_BOOT_LW;
      otrs_pkg::S_BOOT_LW: if (ren_done) state_d = otrs_pkg::S_BOOT_T;
      otrs_pkg::S_BOOT_T:  state_d = otrs_pkg::S_BOOT_TW;
      otrs_pkg::S_BOOT_TW: if (ren_done) state_d = otrs_pkg::S_IDLE;
      otrs_pkg::S_IDLE:    if (in_valid_i) state_d = otrs_pkg::S_SVC;
      otrs_pkg::S_SVC:     state_d = svc_go ? otrs_pkg::S_CHK : otrs_pkg::S_OUT;
      otrs_pkg::S_CHK: begin
        if (nl_q) state_d = otrs_pkg::S_RL;
        else if (nt_q) state_d = otrs_pkg::S_RT;
        else state_d = otrs_pkg::S_PLAN;
      end
      otrs_pkg::S_RL:  state_d = otrs_pkg::S_RLW;
      otrs_pkg::S_RLW: if (ren_done) state_d = otrs_pkg::S_CHK;
      otrs_pkg::S_RT:  state_d = otrs_pkg::S_RTW;
      otrs_pkg::S_RTW: if (ren_done) state_d = otrs_pkg::S_CHK;
      otrs_pkg::S_PLAN: begin
        if (phase_q == otrs_pkg::PH_RUN || in_q.bus_busy || chunk == 3'd0) begin
          state_d = otrs_pkg::S_OUT;
        end else begin
          state_d = otrs_pkg::S_GRD;
        end
      end
      otrs_pkg::S_GRD: state_d = otrs_pkg::S_GWR;
      otrs_pkg::S_GWR: state_d = (i_q + 3'd1 == n_q) ? otrs_pkg::S_FIN : otrs_pkg::S_GRD;
      otrs_pkg::S_FIN: state_d = otrs_pkg::S_OUT;
      otrs_pkg::S_OUT: if (out_ready_i) state_d = otrs_pkg::S_IDLE;
      default: state_d = otrs_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    phase_d = phase_q;     src_d = src_q;           in_d = in_q;
    pend_d = pend_q;       init_pos_d = init_pos_q; clr_page_d = clr_page_q;
    clr_col_d = clr_col_q; div_d = div_q;           shown_mode_d = shown_mode_q;
    shown_time_d = shown_time_q;
    lbl_stale_d = lbl_stale_q; tim_stale_d = tim_stale_q;
    draw_src_d = draw_src_q;   draw_span_d = draw_span_q;
    draw_pos_d = draw_pos_q;   draw_page_d = draw_page_q;
    nl_d = nl_q; nt_d = nt_q; n_d = n_q; i_d = i_q; base_d = base_q;
    wl_d = wl_q; wp_d = wp_q; pv_d = pv_q; rb_d = rb_q; cnt_d = cnt_q; pkt_d = pkt_q;
    ren_req = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      otrs_pkg::S_BOOT_L: ren_req.start = 1'b1;
      otrs_pkg::S_BOOT_T: begin
        ren_req.start   = 1'b1;
        ren_req.is_time = 1'b1;
      end
      otrs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        in_d  = in_data_i;
        pv_d  = 1'b0;
        rb_d  = 1'b0;
        cnt_d = 4'd0;
        pkt_d = 64'd0;
      end
      otrs_pkg::S_SVC: begin
        if (pend_q && !in_q.bus_busy) begin
          pend_d = 1'b0;
          if (in_q.bus_error) begin
            rb_d    = 1'b1;
            phase_d = otrs_pkg::PH_FAILED;
          end
        end
        nl_d = 1'b0;
        nt_d = 1'b0;
        if (svc_go) begin
          div_d = div_inc;
          if (div_inc >= refresh_q) begin
            div_d = 16'd0;
            nl_d  = in_q.mission_mode != shown_mode_q;
            nt_d  = in_q.elapsed_ms != shown_time_q;
          end
        end
      end
      otrs_pkg::S_RL: begin
        ren_req.start = 1'b1;
        ren_req.mode  = in_q.mission_mode;
      end
      otrs_pkg::S_RLW: begin
        if (ren_done) begin
          shown_mode_d = in_q.mission_mode;
          lbl_stale_d  = 1'b1;
          nl_d         = 1'b0;
        end
      end
      otrs_pkg::S_RT: begin
        ren_req.start   = 1'b1;
        ren_req.is_time = 1'b1;
        ren_req.ms      = in_q.elapsed_ms;
      end
      otrs_pkg::S_RTW: begin
        if (ren_done) begin
          shown_time_d = in_q.elapsed_ms;
          tim_stale_d  = 1'b1;
          nt_d         = 1'b0;
        end
      end
      otrs_pkg::S_PLAN: begin
        i_d  = 3'd0;
        n_d  = chunk;
        wl_d = 8'(DISPLAY_WIDTH - 1);
        wp_d = clr_page_q[2:0];
        base_d = 8'd0;
        pkt_d[7:0] = otrs_pkg::CTRL_DATA;
        unique case (phase_q)
          otrs_pkg::PH_INIT: begin
            src_d = otrs_pkg::SRC_INIT;
            base_d = {3'd0, init_pos_q};
            pkt_d[7:0] = otrs_pkg::CTRL_CMD;
          end
          otrs_pkg::PH_CLEAR_WIN: begin
            src_d = otrs_pkg::SRC_WIN;
            pkt_d[7:0] = otrs_pkg::CTRL_CMD;
          end
          otrs_pkg::PH_DRAW_WIN: begin
            src_d = otrs_pkg::SRC_WIN;
            wl_d  = draw_span_q - 8'd1;
            wp_d  = draw_page_q;
            pkt_d[7:0] = otrs_pkg::CTRL_CMD;
          end
          otrs_pkg::PH_CLEAR_DATA: src_d = otrs_pkg::SRC_ZERO;
          otrs_pkg::PH_DRAW_DATA: begin
            src_d  = draw_src_q ? otrs_pkg::SRC_TIME : otrs_pkg::SRC_LABEL;
            base_d = draw_pos_q;
          end
          default: src_d = otrs_pkg::SRC_ZERO;
        endcase
        if (phase_q == otrs_pkg::PH_RUN) begin
          pkt_d[7:0] = 8'h00;
          if (lbl_stale_q) begin
            lbl_stale_d = 1'b0;
            draw_src_d  = 1'b0;
            draw_span_d = 8'(LABEL_BYTES);
            draw_pos_d  = 8'd0;
            draw_page_d = label_page_q;
            phase_d     = otrs_pkg::PH_DRAW_WIN;
          end else if (tim_stale_q) begin
            tim_stale_d = 1'b0;
            draw_src_d  = 1'b1;
            draw_span_d = 8'(TIME_BYTES);
            draw_pos_d  = 8'd0;
            draw_page_d = time_page_q;
            phase_d     = otrs_pkg::PH_DRAW_WIN;
          end
        end else if (in_q.bus_busy || chunk == 3'd0) begin
          pkt_d[7:0] = 8'h00;
        end else begin
          pv_d  = 1'b1;
          cnt_d = {1'b0, chunk} + 4'd1;
        end
      end
      otrs_pkg::S_GWR: begin
        pkt_d[8*(int'(i_q)+1) +: 8] = pkt_byte;
        i_d = i_q + 3'd1;
      end
      otrs_pkg::S_FIN: begin
        pend_d = 1'b1;
        unique case (phase_q)
          otrs_pkg::PH_INIT: begin
            init_pos_d = init_pos_q + 5'(n_q);
            if (init_pos_d >= otrs_pkg::INIT_LEN) phase_d = otrs_pkg::PH_CLEAR_WIN;
          end
          otrs_pkg::PH_CLEAR_WIN: begin
            clr_col_d = 8'd0;
            phase_d   = otrs_pkg::PH_CLEAR_DATA;
          end
          otrs_pkg::PH_CLEAR_DATA: begin
            clr_col_d = clr_col_q + 8'(n_q);
            if (clr_col_d >= 8'(DISPLAY_WIDTH)) begin
              clr_page_d = clr_page_q + 4'd1;
              phase_d = (clr_page_d >= 4'(PAGE_COUNT)) ? otrs_pkg::PH_RUN
                                                      : otrs_pkg::PH_CLEAR_WIN;
            end
          end
          otrs_pkg::PH_DRAW_WIN: phase_d = otrs_pkg::PH_DRAW_DATA;
          otrs_pkg::PH_DRAW_DATA: begin
            draw_pos_d = draw_pos_q + 8'(n_q);
            if (draw_pos_d >= draw_span_q) phase_d = otrs_pkg::PH_RUN;
          end
          default: ;
        endcase
      end
      otrs_pkg::S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign out_data_o.packet_valid = pv_q;
  assign out_data_o.byte_count   = cnt_q;
  assign out_data_o.packet_bytes = pkt_q;
  assign out_data_o.reset_bus    = rb_q;
  assign out_data_o.failed       = phase_q == otrs_pkg::PH_FAILED;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= otrs_pkg::S_BOOT_L;
      phase_q      <= otrs_pkg::PH_INIT;
      pend_q       <= 1'b0;
      init_pos_q   <= 5'd0;
      clr_page_q   <= 4'd0;
      clr_col_q    <= 8'd0;
      div_q        <= 16'd0;
      shown_mode_q <= 2'd0;
      shown_time_q <= '1;
      lbl_stale_q  <= 1'b1;
      tim_stale_q  <= 1'b1;
      draw_src_q   <= 1'b0;
      draw_span_q  <= 8'd0;
      draw_pos_q   <= 8'd0;
      draw_page_q  <= 3'd0;
      nl_q         <= 1'b0;
      nt_q         <= 1'b0;
      i_q          <= 3'd0;
      n_q          <= 3'd0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      pend_q       <= pend_d;
      init_pos_q   <= init_pos_d;
      clr_page_q   <= clr_page_d;
      clr_col_q    <= clr_col_d;
      div_q        <= div_d;
      shown_mode_q <= shown_mode_d;
      shown_time_q <= shown_time_d;
      lbl_stale_q  <= lbl_stale_d;
      tim_stale_q  <= tim_stale_d;
      draw_src_q   <= draw_src_d;
      draw_span_q  <= draw_span_d;
      draw_pos_q   <= draw_pos_d;
      draw_page_q  <= draw_page_d;
      nl_q         <= nl_d;
      nt_q         <= nt_d;
      i_q          <= i_d;
      n_q          <= n_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    src_q  <= src_d;
    base_q <= base_d;
    wl_q   <= wl_d;
    wp_q   <= wp_d;
    pv_q   <= pv_d;
    rb_q   <= rb_d;
    cnt_q  <= cnt_d;
    pkt_q  <= pkt_d;
  end

  // A beat with a packet carries two to MaxBytes bytes; without one, none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.packet_valid |->
      out_data_o.byte_count >= 4'd2 && out_data_o.byte_count <= 4'(MaxBytes))
    else $error("packet byte count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.packet_valid |-> out_data_o.byte_count == 4'd0)
    else $error("byte count without packet");

  // A sent packet always leaves a transfer pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.packet_valid |-> pend_q)
    else $error("packet sent without pending transfer");

  // The failed state holds until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(phase_q == otrs_pkg::PH_FAILED) |-> phase_q == otrs_pkg::PH_FAILED)
    else $error("left failed state");

  // Renderer is only started from its idle state, never mid-tick delivery
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ren_req.start |-> !out_valid_o && !in_ready_o)
    else $error("render started while a channel is open");

endmodule
